### hw/rtl/assert_macros.svh
// Assertion macros for the checker file of the head pose mapper.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HPM_ASSERT_IMPL(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("assertion failed: %m");

// Next-cycle implication, disabled while reset is asserted.
`define HPM_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("assertion failed: %m");

`endif

### hw/rtl/hpm_pkg.sv
// Types and constants shared by the head pose mapper files.
`default_nettype none

package hpm_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 48;

    localparam logic [15:0] ONE_Q15     = 16'd32768;
    localparam logic [14:0] FS_MIN      = 15'd128;
    localparam logic [15:0] EYE_DEN_MIN = 16'd3;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_MIN_CONFIDENCE,
        CFG_DEADZONE_ANGLE,
        CFG_YAW_FULL_SCALE,
        CFG_PITCH_FULL_SCALE,
        CFG_EYE_THRESHOLD,
        CFG_SMOOTHING_ALPHA,
        CFG_FALLBACK_WEIGHT,
        CFG_FALLBACK_POSE
    } cfg_index_t;

    typedef enum logic [1:0] {
        GATE_OK,
        GATE_NO_FACE,
        GATE_LOW_CONF,
        GATE_INVALID
    } gate_t;

    typedef enum logic [2:0] {
        CAUSE_NONE,
        CAUSE_NO_FACE,
        CAUSE_LOW_CONF,
        CAUSE_INVALID,
        CAUSE_MESH,
        CAUSE_DISABLED
    } cause_t;

    typedef enum logic {
        CLAMP_ANGLE,
        CLAMP_UNIT
    } clamp_t;

    typedef struct packed {
        logic               face_found;
        logic [15:0]        confidence;
        logic signed [15:0] yaw_angle;
        logic signed [15:0] pitch_angle;
        logic [15:0]        eye_opening;
        logic               sample_invalid;
        logic               mesh_error;
    } sample_t;

    typedef struct packed {
        logic signed [15:0] smooth_yaw;
        logic signed [15:0] smooth_pitch;
        logic [15:0]        smooth_eye;
        logic [1:0]         gate_status;
        logic               fallback_active;
        logic [2:0]         fallback_cause;
    } result_t;

    typedef struct packed {
        logic [31:0] dividend;
        logic [15:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic signed [17:0] a;
        logic signed [17:0] b;
        logic [15:0]        w;
        clamp_t             mode;
    } mix_req_t;

endpackage

`default_nettype wire

### hw/rtl/hpm_if.sv
// Handshake channel interfaces of the head pose mapper.
`default_nettype none

interface hpm_sample_if;
    logic              valid;
    logic              ready;
    hpm_pkg::sample_t  data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface hpm_result_if;
    logic              valid;
    logic              ready;
    hpm_pkg::result_t  data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface hpm_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [hpm_pkg::CFG_INDEX_W-1:0]     index;
    logic [hpm_pkg::CFG_DATA_W-1:0]      data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### hw/rtl/hpm_div.sv
// Restoring divider, one quotient bit per cycle, quotient saturated at 32768.
`default_nettype none

module hpm_div (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  hpm_pkg::div_req_t req,
    output logic              done,
    output logic [15:0]       quot
);

    localparam int QBITS = 15;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [3:0]        cnt_reg, cnt_next;
    logic [31:0]       rem_reg, rem_next;
    logic [31:0]       dsh_reg, dsh_next;
    logic [QBITS-1:0]  q_reg, q_next;
    logic              sat_reg, sat_next;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        q_next    = q_reg;
        sat_next  = sat_reg;
        if (start)
        begin
            q_next = '0;
            // quotient of 32768 or more: saturate without iterating
            if (req.dividend >= {1'b0, req.divisor, 15'd0})
            begin
                sat_next  = 1'b1;
                done_next = 1'b1;
                busy_next = 1'b0;
            end
            else
            begin
                sat_next  = 1'b0;
                rem_next  = req.dividend;
                dsh_next  = {2'b00, req.divisor, 14'd0};
                cnt_next  = 4'(QBITS);
                busy_next = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            if (rem_reg >= dsh_reg)
            begin
                rem_next = rem_reg - dsh_reg;
                q_next   = {q_reg[QBITS-2:0], 1'b1};
            end
            else
            begin
                q_next = {q_reg[QBITS-2:0], 1'b0};
            end
            dsh_next = dsh_reg >> 1;
            cnt_next = cnt_reg - 4'd1;
            if (cnt_reg == 4'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        q_reg   <= q_next;
        sat_reg <= sat_next;
    end

    assign done = done_reg;
    assign quot = {sat_reg, q_reg};

endmodule

`default_nettype wire

### hw/rtl/hpm_mix.sv
// Two-stage blend unit: floor((a*(32768-w) + b*w + 16384) / 32768), clamped.
`default_nettype none

module hpm_mix (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  hpm_pkg::mix_req_t  req,
    output logic               done,
    output logic signed [17:0] res
);

    logic signed [18:0] diff;
    logic signed [35:0] prod;
    logic signed [37:0] sum;
    logic signed [22:0] rnd;
    logic signed [17:0] clamped;

    logic               v1_reg, v2_reg;
    logic signed [35:0] prod_reg;
    logic signed [17:0] a_reg;
    hpm_pkg::clamp_t    mode_reg;
    logic signed [17:0] res_reg;

    // a*(32768-w) + b*w == a*32768 + (b-a)*w
    always_comb
    begin
        diff = $signed({req.b[17], req.b}) - $signed({req.a[17], req.a});
        prod = diff * $signed({1'b0, req.w});
    end

    always_comb
    begin
        sum = $signed({{5{a_reg[17]}}, a_reg, 15'd0})
            + $signed({{2{prod_reg[35]}}, prod_reg})
            + 38'sd16384;
        rnd = sum[37:15];
        case (mode_reg)
            hpm_pkg::CLAMP_ANGLE:
            begin
                if (rnd > 23'sd32767)
                    clamped = 18'sd32767;
                else if (rnd < -23'sd32768)
                    clamped = -18'sd32768;
                else
                    clamped = rnd[17:0];
            end
            hpm_pkg::CLAMP_UNIT:
            begin
                if (rnd < 23'sd0)
                    clamped = 18'sd0;
                else if (rnd > 23'sd32768)
                    clamped = 18'sd32768;
                else
                    clamped = rnd[17:0];
            end
            default: clamped = rnd[17:0];
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            prod_reg <= prod;
            a_reg    <= req.a;
            mode_reg <= req.mode;
        end
        if (v1_reg)
            res_reg <= clamped;
    end

    assign done = v2_reg;
    assign res  = res_reg;

endmodule

`default_nettype wire

### hw/rtl/head_pose_param_mapper.sv
// Top level of the head pose mapper: configuration, sequencer and output register.
`default_nettype none

// Head pose parameter mapper. One face-tracking sample per transfer on the
// sample channel yields one result transfer on the result channel. A sample
// passes the gate only when a face was found, its confidence reaches
// min_confidence and it is not flagged invalid; gate_status reports the first
// failing check, with an invalid sample taking precedence. For a passed sample
// yaw and pitch lose the deadzone and are divided by their full-scale angle to
// Q1.15 (-32768..32767), and the eye opening above eye_threshold is divided by
// the remaining span (at least 3 LSB) to 0..32768; all quotients round to
// nearest. A failed gate gives zeros. Any fault, a mesh error included, blends
// the three values toward fallback_pose by fallback_weight when that weight is
// nonzero (fallback_active set); with a zero weight fallback_cause reads
// "disabled". Three exponential smoothers with weight smoothing_alpha produce
// the outputs. All arithmetic runs through two shared units under one
// sequencer: a restoring divider that retires one quotient bit per cycle,
// finishes early when the quotient saturates and is not started when the
// deadzone or the eye threshold zeroes the value, and a two-stage
// multiply-round-clamp unit for each blend or smoothing step. A rejected
// sample skips the divider. The sample channel is not ready while a sample
// is in work and returns ready at the same clock edge that loads the result,
// so the next sample is taken while a finished result still waits in the
// output register; a further result holds in the sequencer until that
// register frees. The configuration channel is always ready; the user must
// write it only while the block is idle, which the block does not enforce.
module head_pose_param_mapper (
    input  logic         clk,
    input  logic         rst_n,
    hpm_sample_if.sink   sample,
    hpm_result_if.source result,
    hpm_cfg_if.sink      cfg
);

    localparam logic [1:0] K_YAW   = 2'd0;
    localparam logic [1:0] K_PITCH = 2'd1;
    localparam logic [1:0] K_EYE   = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV_ISSUE,
        S_DIV_WAIT,
        S_MIX_ISSUE,
        S_MIX_WAIT,
        S_DONE
    } state_t;

    // configuration registers
    logic [15:0] conf_floor_reg;
    logic [13:0] deadzone_reg;
    logic [14:0] yaw_fs_reg;
    logic [14:0] pitch_fs_reg;
    logic [15:0] eye_thr_reg;
    logic [15:0] alpha_reg;
    logic [15:0] fb_weight_reg;
    logic [47:0] fb_pose_reg;

    // clamped views of the configuration
    logic [15:0] conf_floor;
    logic [15:0] eye_thr;
    logic [15:0] alpha;
    logic [15:0] fb_weight;
    logic [15:0] fb_eye;
    logic [14:0] yaw_fs;
    logic [14:0] pitch_fs;

    // sequencer
    state_t             state_reg, state_next;
    logic [1:0]         k_reg, k_next;
    logic               smooth_reg, smooth_next;
    logic               out_valid_reg, out_valid_next;
    hpm_pkg::result_t   out_data_reg, out_data_next;
    logic signed [15:0] acc_yaw_reg, acc_yaw_next;
    logic signed [15:0] acc_pitch_reg, acc_pitch_next;
    logic [15:0]        acc_eye_reg, acc_eye_next;

    // captured sample and per-sample values
    logic signed [15:0] yaw_in_reg;
    logic signed [15:0] pitch_in_reg;
    logic [15:0]        eye_in_reg;
    hpm_pkg::gate_t     gate_reg;
    hpm_pkg::cause_t    cause_reg;
    logic               fault_reg;
    logic signed [17:0] val_reg [3];
    logic signed [17:0] val_next [3];

    // sample decode
    logic            take;
    hpm_pkg::gate_t  gate_new;
    hpm_pkg::cause_t cause_new;
    logic            fault_new;
    logic            out_free;
    logic            blend_en;

    // divider setup
    logic signed [15:0] ang_in;
    logic [16:0]        ang_ext;
    logic [16:0]        ang_mag;
    logic [14:0]        ang_fs;
    logic               ang_zero;
    logic [16:0]        ang_num;
    logic [16:0]        eye_num;
    logic               eye_zero;
    logic [16:0]        eye_den_raw;
    logic [15:0]        eye_den;
    logic               is_eye;
    logic [16:0]        div_num;
    logic               div_zero;
    logic signed [17:0] div_val;

    // shared units
    hpm_pkg::div_req_t  div_req;
    logic               div_start;
    logic               div_done;
    logic [15:0]        div_quot;
    hpm_pkg::mix_req_t  mix_req;
    logic               mix_start;
    logic               mix_done;
    logic signed [17:0] mix_res;

    hpm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .req   (div_req),
        .done  (div_done),
        .quot  (div_quot)
    );

    hpm_mix u_mix (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mix_start),
        .req   (mix_req),
        .done  (mix_done),
        .res   (mix_res)
    );

    // clamp or floor register values that lie outside their meaningful range
    always_comb
    begin
        conf_floor = (conf_floor_reg > hpm_pkg::ONE_Q15) ? hpm_pkg::ONE_Q15 : conf_floor_reg;
        eye_thr    = (eye_thr_reg > hpm_pkg::ONE_Q15) ? hpm_pkg::ONE_Q15 : eye_thr_reg;
        alpha      = (alpha_reg > hpm_pkg::ONE_Q15) ? hpm_pkg::ONE_Q15 : alpha_reg;
        fb_weight  = (fb_weight_reg > hpm_pkg::ONE_Q15) ? hpm_pkg::ONE_Q15 : fb_weight_reg;
        fb_eye     = (fb_pose_reg[47:32] > hpm_pkg::ONE_Q15) ? hpm_pkg::ONE_Q15
                                                            : fb_pose_reg[47:32];
        yaw_fs     = (yaw_fs_reg < hpm_pkg::FS_MIN) ? hpm_pkg::FS_MIN : yaw_fs_reg;
        pitch_fs   = (pitch_fs_reg < hpm_pkg::FS_MIN) ? hpm_pkg::FS_MIN : pitch_fs_reg;
        blend_en   = (fb_weight != 16'd0);
    end

    // gate and fault decode of the incoming sample
    always_comb
    begin
        gate_new = hpm_pkg::GATE_OK;
        if (!sample.data.face_found)
            gate_new = hpm_pkg::GATE_NO_FACE;
        else if (sample.data.confidence < conf_floor)
            gate_new = hpm_pkg::GATE_LOW_CONF;
        if (sample.data.sample_invalid)
            gate_new = hpm_pkg::GATE_INVALID;

        case (gate_new)
            hpm_pkg::GATE_NO_FACE:  cause_new = hpm_pkg::CAUSE_NO_FACE;
            hpm_pkg::GATE_LOW_CONF: cause_new = hpm_pkg::CAUSE_LOW_CONF;
            hpm_pkg::GATE_INVALID:  cause_new = hpm_pkg::CAUSE_INVALID;
            default:
                cause_new = sample.data.mesh_error ? hpm_pkg::CAUSE_MESH
                                                   : hpm_pkg::CAUSE_NONE;
        endcase

        fault_new = (gate_new != hpm_pkg::GATE_OK) || sample.data.mesh_error;
    end

    // operands of the division for the value selected by k
    always_comb
    begin
        is_eye  = (k_reg == K_EYE);
        ang_in  = (k_reg == K_PITCH) ? pitch_in_reg : yaw_in_reg;
        ang_fs  = (k_reg == K_PITCH) ? pitch_fs : yaw_fs;
        ang_ext = {ang_in[15], ang_in};
        ang_mag = ang_in[15] ? (~ang_ext + 17'd1) : ang_ext;
        ang_zero = (ang_mag <= {3'b000, deadzone_reg});
        ang_num  = ang_mag - {3'b000, deadzone_reg};

        eye_zero    = (eye_in_reg <= eye_thr);
        eye_num     = {1'b0, eye_in_reg} - {1'b0, eye_thr};
        eye_den_raw = {1'b0, hpm_pkg::ONE_Q15} - {1'b0, eye_thr};
        eye_den     = (eye_den_raw < {1'b0, hpm_pkg::EYE_DEN_MIN}) ? hpm_pkg::EYE_DEN_MIN
                                                                   : eye_den_raw[15:0];

        div_num          = is_eye ? eye_num : ang_num;
        div_zero         = is_eye ? eye_zero : ang_zero;
        div_req.divisor  = is_eye ? eye_den : {1'b0, ang_fs};
        // add half the divisor to round to nearest
        div_req.dividend = {div_num, 15'd0} + {17'd0, div_req.divisor[15:1]};

        // restore the sign and saturate the positive angle at 32767
        if (is_eye)
            div_val = $signed({2'b00, div_quot});
        else if (ang_in[15])
            div_val = $signed(18'd0 - {2'b00, div_quot});
        else if (div_quot > 16'd32767)
            div_val = 18'sd32767;
        else
            div_val = $signed({2'b00, div_quot});
    end

    // operands of the blend or smoothing step for the value selected by k
    always_comb
    begin
        logic signed [17:0] acc_sel;
        logic signed [17:0] fb_sel;
        case (k_reg)
            K_YAW:
            begin
                acc_sel = {{2{acc_yaw_reg[15]}}, acc_yaw_reg};
                fb_sel  = {{2{fb_pose_reg[15]}}, fb_pose_reg[15:0]};
            end
            K_PITCH:
            begin
                acc_sel = {{2{acc_pitch_reg[15]}}, acc_pitch_reg};
                fb_sel  = {{2{fb_pose_reg[31]}}, fb_pose_reg[31:16]};
            end
            default:
            begin
                acc_sel = $signed({2'b00, acc_eye_reg});
                fb_sel  = $signed({2'b00, fb_eye});
            end
        endcase
        mix_req.a    = smooth_reg ? acc_sel : val_reg[k_reg];
        mix_req.b    = smooth_reg ? val_reg[k_reg] : fb_sel;
        mix_req.w    = smooth_reg ? alpha : fb_weight;
        mix_req.mode = is_eye ? hpm_pkg::CLAMP_UNIT : hpm_pkg::CLAMP_ANGLE;
    end

    assign take     = sample.valid && sample.ready;
    assign out_free = !out_valid_reg || result.ready;

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        k_next         = k_reg;
        smooth_next    = smooth_reg;
        acc_yaw_next   = acc_yaw_reg;
        acc_pitch_next = acc_pitch_reg;
        acc_eye_next   = acc_eye_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !result.ready;
        val_next       = val_reg;
        div_start      = 1'b0;
        mix_start      = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (take)
                begin
                    k_next = K_YAW;
                    for (int i = 0; i < 3; i++)
                        val_next[i] = '0;
                    if (gate_new == hpm_pkg::GATE_OK)
                    begin
                        state_next = S_DIV_ISSUE;
                    end
                    else
                    begin
                        // rejected sample: values stay zero, blend (if enabled) without dividing
                        smooth_next = !(fault_new && blend_en);
                        state_next  = S_MIX_ISSUE;
                    end
                end
            end

            S_DIV_ISSUE:
            begin
                if (div_zero)
                begin
                    // inside deadzone or at or below threshold: keep zero, skip the divide
                    if (k_reg == K_EYE)
                    begin
                        k_next      = K_YAW;
                        smooth_next = !(fault_reg && blend_en);
                        state_next  = S_MIX_ISSUE;
                    end
                    else
                    begin
                        k_next = k_reg + 2'd1;
                    end
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = S_DIV_WAIT;
                end
            end

            S_DIV_WAIT:
            begin
                if (div_done)
                begin
                    val_next[k_reg] = div_val;
                    if (k_reg == K_EYE)
                    begin
                        k_next      = K_YAW;
                        smooth_next = !(fault_reg && blend_en);
                        state_next  = S_MIX_ISSUE;
                    end
                    else
                    begin
                        k_next     = k_reg + 2'd1;
                        state_next = S_DIV_ISSUE;
                    end
                end
            end

            S_MIX_ISSUE:
            begin
                mix_start  = 1'b1;
                state_next = S_MIX_WAIT;
            end

            S_MIX_WAIT:
            begin
                if (mix_done)
                begin
                    if (smooth_reg)
                    begin
                        case (k_reg)
                            K_YAW:   acc_yaw_next   = mix_res[15:0];
                            K_PITCH: acc_pitch_next = mix_res[15:0];
                            default: acc_eye_next   = mix_res[15:0];
                        endcase
                    end
                    else
                    begin
                        val_next[k_reg] = mix_res;
                    end

                    if (k_reg != K_EYE)
                    begin
                        k_next     = k_reg + 2'd1;
                        state_next = S_MIX_ISSUE;
                    end
                    else if (!smooth_reg)
                    begin
                        // blend done, start smoothing
                        k_next      = K_YAW;
                        smooth_next = 1'b1;
                        state_next  = S_MIX_ISSUE;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end

            S_DONE:
            begin
                // hold until the output register can take the result
                if (out_free)
                begin
                    out_data_next.smooth_yaw      = acc_yaw_reg;
                    out_data_next.smooth_pitch    = acc_pitch_reg;
                    out_data_next.smooth_eye      = acc_eye_reg;
                    out_data_next.gate_status     = gate_reg;
                    out_data_next.fallback_active = fault_reg && blend_en;
                    if (!fault_reg)
                        out_data_next.fallback_cause = hpm_pkg::CAUSE_NONE;
                    else if (blend_en)
                        out_data_next.fallback_cause = cause_reg;
                    else
                        out_data_next.fallback_cause = hpm_pkg::CAUSE_DISABLED;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            k_reg         <= K_YAW;
            smooth_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            acc_yaw_reg   <= '0;
            acc_pitch_reg <= '0;
            acc_eye_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            k_reg         <= k_next;
            smooth_reg    <= smooth_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
            acc_yaw_reg   <= acc_yaw_next;
            acc_pitch_reg <= acc_pitch_next;
            acc_eye_reg   <= acc_eye_next;
        end
    end

    // capture the sample and keep the working values
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            yaw_in_reg   <= sample.data.yaw_angle;
            pitch_in_reg <= sample.data.pitch_angle;
            eye_in_reg   <= sample.data.eye_opening;
            gate_reg     <= gate_new;
            cause_reg    <= cause_new;
            fault_reg    <= fault_new;
        end
        for (int i = 0; i < 3; i++)
            val_reg[i] <= val_next[i];
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            conf_floor_reg <= 16'd16384;
            deadzone_reg   <= 14'd256;
            yaw_fs_reg     <= 15'd3840;
            pitch_fs_reg   <= 15'd2560;
            eye_thr_reg    <= 16'd6554;
            alpha_reg      <= 16'd16384;
            fb_weight_reg  <= 16'd0;
            fb_pose_reg    <= 48'd0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                hpm_pkg::CFG_MIN_CONFIDENCE:   conf_floor_reg <= cfg.data[15:0];
                hpm_pkg::CFG_DEADZONE_ANGLE:   deadzone_reg   <= cfg.data[13:0];
                hpm_pkg::CFG_YAW_FULL_SCALE:   yaw_fs_reg     <= cfg.data[14:0];
                hpm_pkg::CFG_PITCH_FULL_SCALE: pitch_fs_reg   <= cfg.data[14:0];
                hpm_pkg::CFG_EYE_THRESHOLD:    eye_thr_reg    <= cfg.data[15:0];
                hpm_pkg::CFG_SMOOTHING_ALPHA:  alpha_reg      <= cfg.data[15:0];
                hpm_pkg::CFG_FALLBACK_WEIGHT:  fb_weight_reg  <= cfg.data[15:0];
                hpm_pkg::CFG_FALLBACK_POSE:    fb_pose_reg    <= cfg.data[47:0];
                default: ;
            endcase
        end
    end

    assign sample.ready = (state_reg == S_IDLE);
    assign cfg.ready    = 1'b1;
    assign result.valid = out_valid_reg;
    assign result.data  = out_data_reg;

endmodule

`default_nettype wire

### hw/rtl/hpm_checker.sv
// Port-level checks of the head pose mapper and their bind.
`default_nettype none
`include "assert_macros.svh"

module hpm_checker (
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             sample_valid,
    input wire logic             sample_ready,
    input wire logic             result_valid,
    input wire logic             result_ready,
    input wire hpm_pkg::result_t result_data
);

    // one sample in work at a time
    `HPM_ASSERT_NEXT(a_busy_after_take, clk, rst_n, sample_valid && sample_ready, !sample_ready)

    // a failed gate reports its own cause unless fallback is disabled
    `HPM_ASSERT_IMPL(a_cause_follows_gate, clk, rst_n, result_valid && result_data.gate_status != hpm_pkg::GATE_OK, result_data.fallback_cause == 3'(result_data.gate_status) || result_data.fallback_cause == hpm_pkg::CAUSE_DISABLED)

    // an active fallback always names a real fault
    `HPM_ASSERT_IMPL(a_active_has_cause, clk, rst_n, result_valid && result_data.fallback_active, result_data.fallback_cause != hpm_pkg::CAUSE_NONE && result_data.fallback_cause != hpm_pkg::CAUSE_DISABLED)

    `HPM_ASSERT_IMPL(a_eye_in_range, clk, rst_n, result_valid, result_data.smooth_eye <= hpm_pkg::ONE_Q15)

    // a stalled result holds
    `HPM_ASSERT_NEXT(a_result_hold, clk, rst_n, result_valid && !result_ready, result_valid && $stable(result_data))

endmodule

bind head_pose_param_mapper hpm_checker u_hpm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .sample_valid (sample.valid),
    .sample_ready (sample.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .result_data  (result.data)
);

`default_nettype wire

### tb/tb_head_pose_param_mapper.sv
// Self-checking testbench for the head pose parameter mapper.
`timescale 1ns / 100ps

module tb_head_pose_param_mapper;

    localparam int SINK_HOLD_CYCLES = 800;
    localparam int PHASES           = 12;
    localparam int PHASE_SAMPLES    = 86;
    localparam int SETTLE_CYCLES    = 150;

    logic clk = 1'b0;
    logic rst_n;

    hpm_sample_if sample_ch ();
    hpm_result_if result_ch ();
    hpm_cfg_if    cfg_ch ();

    head_pose_param_mapper dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    always #1 clk = ~clk;

    // Shadow copy of the configuration registers, at their register widths.
    logic [15:0] conf_floor_r;
    logic [13:0] deadzone_r;
    logic [14:0] yaw_fs_r;
    logic [14:0] pitch_fs_r;
    logic [15:0] eye_thr_r;
    logic [15:0] alpha_r;
    logic [15:0] fb_weight_r;
    logic [47:0] fb_pose_r;

    // Smoother state of the predictor.
    longint yaw_acc, pitch_acc, eye_acc;

    hpm_pkg::sample_t samples_to_send [$];
    hpm_pkg::result_t expected_poses [$];

    int  errors;
    int  n_queued;
    int  results_seen;
    int  gate_seen [4];
    int  blends;
    int  settings_used;
    int  send_gap;
    int  sink_gap;
    int  sink_hold;
    logic idle_en;
    logic hold_req, hold_ack;

    //------------------------------------------------------------------
    // Predictor: fixed-point behavior of the mapper, one call per
    // accepted sample. Updates the smoother state as a side effect.
    //------------------------------------------------------------------
    function automatic longint clip(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // floor((x + 0.5 LSB) / 2^15); arithmetic shift floors negatives
    function automatic longint round_q15(longint x);
        return (x + 16384) >>> 15;
    endfunction

    function automatic longint blend(longint a, longint b, longint w);
        return round_q15(a * (32768 - w) + b * w);
    endfunction

    // Deadzone, then divide by full scale with round-half-away-from-zero.
    function automatic longint scale_angle(longint v, longint dz, longint fs);
        longint mag, den, q;
        mag = (v < 0) ? -v : v;
        den = (fs < 128) ? 128 : fs;
        if (mag <= dz)
            return 0;
        mag = mag - dz;
        q = ((mag << 15) + den / 2) / den;
        if (v < 0)
            q = -q;
        return clip(q, -32768, 32767);
    endfunction

    function automatic hpm_pkg::result_t predict_smoothed_pose(hpm_pkg::sample_t s);
        hpm_pkg::result_t r;
        hpm_pkg::gate_t   verdict;
        hpm_pkg::cause_t  cause;
        logic    fault, active;
        longint  conf, eye, minc, thr, alpha, fw, num, den, my, mp, me;
        conf    = longint'(s.confidence);
        eye     = longint'(s.eye_opening);
        minc    = clip(longint'(conf_floor_r), 0, 32768);
        thr     = clip(longint'(eye_thr_r), 0, 32768);
        alpha   = clip(longint'(alpha_r), 0, 32768);
        fw      = clip(longint'(fb_weight_r), 0, 32768);
        verdict = hpm_pkg::GATE_OK;
        cause   = hpm_pkg::CAUSE_NONE;
        fault   = 1'b0;
        active  = 1'b0;
        my      = 0;
        mp      = 0;
        me      = 0;

        // No face outranks low confidence; an invalid sample outranks both.
        if (!s.face_found)
        begin
            verdict = hpm_pkg::GATE_NO_FACE;
            cause   = hpm_pkg::CAUSE_NO_FACE;
            fault   = 1'b1;
        end
        else if (conf < minc)
        begin
            verdict = hpm_pkg::GATE_LOW_CONF;
            cause   = hpm_pkg::CAUSE_LOW_CONF;
            fault   = 1'b1;
        end
        if (s.sample_invalid)
        begin
            verdict = hpm_pkg::GATE_INVALID;
            cause   = hpm_pkg::CAUSE_INVALID;
            fault   = 1'b1;
        end
        // Mesh error asks for fallback but leaves the gate alone.
        if (s.mesh_error)
        begin
            if (cause == hpm_pkg::CAUSE_NONE)
                cause = hpm_pkg::CAUSE_MESH;
            fault = 1'b1;
        end

        if (verdict == hpm_pkg::GATE_OK)
        begin
            num = eye - thr;
            den = 32768 - thr;
            if (den < 3)
                den = 3;
            if (num > 0)
                me = clip(((num << 15) + den / 2) / den, 0, 32768);
            my = scale_angle(longint'($signed(s.yaw_angle)), longint'(deadzone_r),
                             longint'(yaw_fs_r));
            mp = scale_angle(longint'($signed(s.pitch_angle)), longint'(deadzone_r),
                             longint'(pitch_fs_r));
        end

        if (!fault)
            cause = hpm_pkg::CAUSE_NONE;
        else if (fw > 0)
        begin
            my = clip(blend(my, longint'($signed(fb_pose_r[15:0])), fw), -32768, 32767);
            mp = clip(blend(mp, longint'($signed(fb_pose_r[31:16])), fw), -32768, 32767);
            me = clip(blend(me, clip(longint'(fb_pose_r[47:32]), 0, 32768), fw), 0, 32768);
            active = 1'b1;
            blends++;
        end
        else
            cause = hpm_pkg::CAUSE_DISABLED;

        yaw_acc   = clip(blend(yaw_acc, my, alpha), -32768, 32767);
        pitch_acc = clip(blend(pitch_acc, mp, alpha), -32768, 32767);
        eye_acc   = clip(blend(eye_acc, me, alpha), 0, 32768);

        r.smooth_yaw      = 16'(yaw_acc);
        r.smooth_pitch    = 16'(pitch_acc);
        r.smooth_eye      = 16'(eye_acc);
        r.gate_status     = verdict;
        r.fallback_active = active;
        r.fallback_cause  = cause;
        gate_seen[verdict]++;
        return r;
    endfunction

    //------------------------------------------------------------------
    // Mismatch reporting: one line per failure.
    //------------------------------------------------------------------
    task automatic flag_mismatch(string what, longint got, longint want);
        errors++;
        $display("[%0t] result %0d: %s got %0d, expected %0d",
                 $time, results_seen, what, got, want);
    endtask

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(15, 60);
        return $urandom_range(0, 3);
    endfunction

    //------------------------------------------------------------------
    // Sample driver: offer queued samples, hold each offer until the
    // transfer, predict at the transfer, then idle for a random gap if enabled.
    //------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_ch.valid <= 1'b0;
            sample_ch.data  <= '0;
            send_gap        <= 0;
        end
        else
        begin
            if (sample_ch.valid && sample_ch.ready)
                expected_poses.insert(expected_poses.size(),
                                      predict_smoothed_pose(sample_ch.data));
            // Advance only when the channel slot is free; otherwise hold.
            if (!sample_ch.valid || sample_ch.ready)
            begin
                if (send_gap != 0)
                begin
                    send_gap        <= send_gap - 1;
                    sample_ch.valid <= 1'b0;
                end
                else if (samples_to_send.size() != 0)
                begin
                    sample_ch.valid <= 1'b1;
                    sample_ch.data  <= samples_to_send.pop_front();
                    send_gap        <= idle_en ? pick_gap() : 0;
                end
                else
                    sample_ch.valid <= 1'b0;
            end
        end
    end

    //------------------------------------------------------------------
    // Long receiver hold-off, counted here; a toggle of hold_req starts it.
    //------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sink_hold <= 0;
            hold_ack  <= 1'b0;
        end
        else if (hold_req != hold_ack)
        begin
            sink_hold <= SINK_HOLD_CYCLES;
            hold_ack  <= hold_req;
        end
        else if (sink_hold != 0)
            sink_hold <= sink_hold - 1;
    end

    //------------------------------------------------------------------
    // Result monitor: check each transfer against the oldest prediction,
    // field by field, and stall ready during the hold-off and, if idling is enabled, at random.
    //------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        hpm_pkg::result_t want;
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
            sink_gap        <= 0;
        end
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                results_seen++;
                if (expected_poses.size() == 0)
                    flag_mismatch("result with no sample outstanding", 0, 0);
                else
                begin
                    want = expected_poses.pop_front();
                    if (result_ch.data.smooth_yaw !== want.smooth_yaw)
                        flag_mismatch("smooth_yaw", result_ch.data.smooth_yaw,
                                      want.smooth_yaw);
                    if (result_ch.data.smooth_pitch !== want.smooth_pitch)
                        flag_mismatch("smooth_pitch", result_ch.data.smooth_pitch,
                                      want.smooth_pitch);
                    if (result_ch.data.smooth_eye !== want.smooth_eye)
                        flag_mismatch("smooth_eye", result_ch.data.smooth_eye,
                                      want.smooth_eye);
                    if (result_ch.data.gate_status !== want.gate_status)
                        flag_mismatch("gate_status", result_ch.data.gate_status,
                                      want.gate_status);
                    if (result_ch.data.fallback_active !== want.fallback_active)
                        flag_mismatch("fallback_active", result_ch.data.fallback_active,
                                      want.fallback_active);
                    if (result_ch.data.fallback_cause !== want.fallback_cause)
                        flag_mismatch("fallback_cause", result_ch.data.fallback_cause,
                                      want.fallback_cause);
                end
            end
            if (sink_hold != 0)
                result_ch.ready <= 1'b0;
            else if (sink_gap != 0)
            begin
                sink_gap        <= sink_gap - 1;
                result_ch.ready <= 1'b0;
            end
            else if (idle_en && $urandom_range(0, 3) == 0)
            begin
                sink_gap        <= pick_gap();
                result_ch.ready <= 1'b0;
            end
            else
                result_ch.ready <= 1'b1;
        end
    end

    //------------------------------------------------------------------
    // Configuration writes; call only while the mapper is idle.
    //------------------------------------------------------------------
    task automatic write_reg(hpm_pkg::cfg_index_t idx, logic [47:0] value);
        @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        case (idx)
            hpm_pkg::CFG_MIN_CONFIDENCE:   conf_floor_r = value[15:0];
            hpm_pkg::CFG_DEADZONE_ANGLE:   deadzone_r   = value[13:0];
            hpm_pkg::CFG_YAW_FULL_SCALE:   yaw_fs_r     = value[14:0];
            hpm_pkg::CFG_PITCH_FULL_SCALE: pitch_fs_r   = value[14:0];
            hpm_pkg::CFG_EYE_THRESHOLD:    eye_thr_r    = value[15:0];
            hpm_pkg::CFG_SMOOTHING_ALPHA:  alpha_r      = value[15:0];
            hpm_pkg::CFG_FALLBACK_WEIGHT:  fb_weight_r  = value[15:0];
            hpm_pkg::CFG_FALLBACK_POSE:    fb_pose_r    = value;
            default: ;
        endcase
    endtask

    task automatic apply_settings(int unsigned mc, int unsigned dz, int unsigned yfs,
                                  int unsigned pfs, int unsigned thr, int unsigned alpha,
                                  int unsigned fw, logic [47:0] pose);
        write_reg(hpm_pkg::CFG_MIN_CONFIDENCE, 48'(mc));
        write_reg(hpm_pkg::CFG_DEADZONE_ANGLE, 48'(dz));
        write_reg(hpm_pkg::CFG_YAW_FULL_SCALE, 48'(yfs));
        write_reg(hpm_pkg::CFG_PITCH_FULL_SCALE, 48'(pfs));
        write_reg(hpm_pkg::CFG_EYE_THRESHOLD, 48'(thr));
        write_reg(hpm_pkg::CFG_SMOOTHING_ALPHA, 48'(alpha));
        write_reg(hpm_pkg::CFG_FALLBACK_WEIGHT, 48'(fw));
        write_reg(hpm_pkg::CFG_FALLBACK_POSE, pose);
        settings_used++;
    endtask

    // Mostly workable settings: small deadzones, one fallback weight in three zero.
    task automatic random_settings();
        int unsigned dz, fw;
        dz = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 1024) : $urandom_range(0, 11520);
        fw = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 32768);
        apply_settings($urandom_range(0, 26000), dz, $urandom_range(128, 23040),
                       $urandom_range(128, 23040), $urandom_range(0, 32768),
                       $urandom_range(0, 32768), fw, {16'($urandom), 32'($urandom)});
    endtask

    //------------------------------------------------------------------
    // Stimulus helpers.
    //------------------------------------------------------------------
    task automatic push_sample(hpm_pkg::sample_t s);
        samples_to_send.insert(samples_to_send.size(), s);
        n_queued++;
    endtask

    function automatic hpm_pkg::sample_t pose_sample(logic found, int conf, int yaw,
                                                     int pitch, int eye, logic invalid,
                                                     logic mesh);
        hpm_pkg::sample_t s;
        s.face_found     = found;
        s.confidence     = conf[15:0];
        s.yaw_angle      = yaw[15:0];
        s.pitch_angle    = pitch[15:0];
        s.eye_opening    = eye[15:0];
        s.sample_invalid = invalid;
        s.mesh_error     = mesh;
        return s;
    endfunction

    // Random angle: mostly in range, some at the deadzone edge, some raw 16 bits.
    function automatic int random_angle();
        int a;
        case ($urandom_range(0, 9))
            0:       a = int'($urandom_range(0, 65535)) - 32768;
            1:
            begin
                a = int'(deadzone_r) + int'($urandom_range(0, 4)) - 2;
                if ($urandom_range(0, 1) != 0)
                    a = -a;
            end
            default: a = int'($urandom_range(0, 46080)) - 23040;
        endcase
        return a;
    endfunction

    // Most samples pass the gate so the scaling paths get exercised.
    function automatic hpm_pkg::sample_t random_sample();
        int minc, thr, conf, eye;
        minc = int'(clip(longint'(conf_floor_r), 0, 32768));
        thr  = int'(clip(longint'(eye_thr_r), 0, 32768));
        case ($urandom_range(0, 9))
            0:       conf = $urandom_range(0, 65535);
            1, 2:    conf = $urandom_range(0, 32768);
            default: conf = $urandom_range(minc, 32768);
        endcase
        case ($urandom_range(0, 19))
            0, 1:    eye = $urandom_range(0, 65535);
            2:       eye = thr + int'($urandom_range(0, 4)) - 2;
            default: eye = $urandom_range(0, 32768);
        endcase
        return pose_sample($urandom_range(0, 9) != 0, conf, random_angle(), random_angle(),
                           eye, $urandom_range(0, 11) == 0, $urandom_range(0, 9) == 0);
    endfunction

    // Field extremes, gate boundaries, gate precedence and every fault kind.
    task automatic queue_corner_samples();
        push_sample(pose_sample(1, 32768, 23040, -23040, 32768, 0, 0));
        push_sample(pose_sample(1, 65535, -32768, 32767, 65535, 0, 0));
        push_sample(pose_sample(1, 16384, 256, -256, 6554, 0, 0));
        push_sample(pose_sample(1, 16384, 257, -257, 6555, 0, 0));
        push_sample(pose_sample(1, 16383, 1000, 1000, 20000, 0, 0));
        push_sample(pose_sample(0, 32768, 1000, -1000, 20000, 0, 0));
        push_sample(pose_sample(1, 32768, -5000, 3000, 10000, 1, 0));
        push_sample(pose_sample(0, 0, 0, 0, 0, 1, 0));
        push_sample(pose_sample(1, 30000, 2000, -2000, 15000, 0, 1));
        push_sample(pose_sample(1, 100, 2000, -2000, 15000, 0, 1));
        push_sample(pose_sample(0, 0, 0, 0, 0, 0, 0));
        push_sample(pose_sample(1, 32768, -23040, 23040, 0, 0, 0));
    endtask

    // Block until every queued sample has produced its result.
    task automatic wait_drained();
        while (results_seen < n_queued)
            @(posedge clk);
        @(posedge clk);
    endtask

    //------------------------------------------------------------------
    // Main sequence.
    //------------------------------------------------------------------
    initial
    begin
        int p, k;
        rst_n           = 1'b0;
        idle_en         = 1'b1;
        hold_req        = 1'b0;
        sample_ch.valid = 1'b0;
        sample_ch.data  = '0;
        result_ch.ready = 1'b0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.index    = hpm_pkg::CFG_MIN_CONFIDENCE;
        cfg_ch.data     = '0;
        conf_floor_r    = 16'd16384;
        deadzone_r      = 14'd256;
        yaw_fs_r        = 15'd3840;
        pitch_fs_r      = 15'd2560;
        eye_thr_r       = 16'd6554;
        alpha_r         = 16'd16384;
        fb_weight_r     = 16'd0;
        fb_pose_r       = 48'd0;
        yaw_acc         = 0;
        pitch_acc       = 0;
        eye_acc         = 0;
        errors          = 0;
        n_queued        = 0;
        results_seen    = 0;
        blends          = 0;
        settings_used   = 1;
        gate_seen       = '{default: 0};

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Corner samples under reset settings: fallback disabled.
        queue_corner_samples();
        wait_drained();

        // Same corners with fallback enabled, so each fault cause shows up blended.
        // Every register is written here once; the sender sits idle until
        // all results are back.
        apply_settings(16384, 256, 3840, 2560, 6554, 16384, 16384,
                       {16'd20000, 16'hD8F0, 16'd12000});
        queue_corner_samples();
        wait_drained();

        for (p = 0; p < PHASES; p++)
        begin
            case (p)
                // Lower extremes: no deadzone, tightest scale, no smoothing lag.
                0: apply_settings(0, 0, 128, 128, 0, 32768, 32768,
                                  {16'h8000, 16'h8000, 16'h7FFF});
                // Upper extremes: frozen smoother, minimal fallback weight.
                1: apply_settings(32768, 11520, 23040, 23040, 32768, 0, 1,
                                  48'hFFFF_FFFF_FFFF);
                // Out-of-range register values, clamped or floored inside.
                2: apply_settings(65535, 16383, 0, 100, 65535, 65535, 65535,
                                  {16'($urandom), 32'($urandom)});
                default: random_settings();
            endcase
            // Every fourth phase runs without any idling on either side.
            idle_en <= (p % 4 != 3);
            for (k = 0; k < PHASE_SAMPLES; k++)
                push_sample(random_sample());
            // Back-pressure: hold the result side long enough to stall the input.
            if (p == 5)
                hold_req <= ~hold_req;
            wait_drained();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (expected_poses.size() != 0)
            flag_mismatch("results never delivered", 0, expected_poses.size());

        $display("Run covered %0d samples under %0d register settings, %0d fallback blends.",
                 n_queued, settings_used, blends);
        $display("Gate outcomes ok/no face/low confidence/invalid: %0d/%0d/%0d/%0d",
                 gate_seen[hpm_pkg::GATE_OK], gate_seen[hpm_pkg::GATE_NO_FACE],
                 gate_seen[hpm_pkg::GATE_LOW_CONF], gate_seen[hpm_pkg::GATE_INVALID]);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Watchdog: several times the slowest legal run.
    initial
    begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
